/* rtl/clnw_pkg.sv */
// Shared types, constants and lookup functions for the character LCD nibble writer.
package clnw_pkg;

	// Request codes on the func input.
	typedef enum logic [2:0] {
		FUNC_CHAR   = 3'd0,
		FUNC_CMD    = 3'd1,
		FUNC_POS    = 3'd2,
		FUNC_NUMBER = 3'd3,
		FUNC_INIT   = 3'd4
	} func_t;

	// Kind of work that the back sequencer carries out.
	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_NUMBER = 2'd1,
		KIND_INIT   = 2'd2
	} kind_t;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned NIB_W    = 4;
	localparam int unsigned NUM_W    = 17;
	localparam int unsigned STEP_W   = 4;
	localparam int unsigned DIGIT_IDX_W = 3;

	// Default depth of the queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [BYTE_W-1:0] CMD_ROW0 = 8'h80;
	localparam logic [BYTE_W-1:0] CMD_ROW1 = 8'hC0;
	localparam logic [NUM_W-1:0]  NUM_MAX  = 17'd99999;

	// High nibble of every ASCII digit character.
	localparam logic [NIB_W-1:0] ASCII_DIGIT_HI = 4'h3;

	// Step on which a plain byte and a ten-write sequence end.
	localparam logic [STEP_W-1:0] LAST_BYTE_STEP = 4'd1;
	localparam logic [STEP_W-1:0] LAST_SEQ_STEP  = 4'd9;

	// One queued request, already classified by the front.
	typedef struct packed {
		kind_t              kind;
		logic [BYTE_W-1:0]  byte_val;
		logic               rs;
		logic [NUM_W-1:0]   value;
	} req_t;

	// Nibbles of the init sequence: 3, 3, 3, 2, then 0x28, 0x0C, 0x01.
	function automatic logic [NIB_W-1:0] init_nibble(input logic [STEP_W-1:0] idx);
		logic [NIB_W-1:0] nib;
		case (idx)
			4'd0:    nib = 4'h3;
			4'd1:    nib = 4'h3;
			4'd2:    nib = 4'h3;
			4'd3:    nib = 4'h2;
			4'd4:    nib = 4'h2;
			4'd5:    nib = 4'h8;
			4'd6:    nib = 4'h0;
			4'd7:    nib = 4'hC;
			4'd8:    nib = 4'h0;
			4'd9:    nib = 4'h1;
			default: nib = 4'h0;
		endcase
		return nib;
	endfunction

	// Decimal weight of each printed digit, most significant first.
	function automatic logic [NUM_W-1:0] digit_weight(input logic [DIGIT_IDX_W-1:0] idx);
		logic [NUM_W-1:0] w;
		case (idx)
			3'd0:    w = 17'd10000;
			3'd1:    w = 17'd1000;
			3'd2:    w = 17'd100;
			3'd3:    w = 17'd10;
			default: w = 17'd1;
		endcase
		return w;
	endfunction

endpackage

/* rtl/clnw_front.sv */
// Front end: classifies an incoming request into a queue record or drops it.
module clnw_front (
	input  logic [2:0]        func,
	input  logic [7:0]        data_byte,
	input  logic [1:0]        row,
	input  logic [7:0]        column,
	input  logic [16:0]       number_value,
	output clnw_pkg::req_t    req,
	output logic              keep
);

	// Decode the request; position on lines 2 and 3 and unused codes give no work.
	always_comb begin
		req.kind     = clnw_pkg::KIND_BYTE;
		req.byte_val = data_byte;
		req.rs       = 1'b0;
		req.value    = (number_value > clnw_pkg::NUM_MAX) ? clnw_pkg::NUM_MAX : number_value;
		keep         = 1'b0;
		unique case (clnw_pkg::func_t'(func))
			clnw_pkg::FUNC_CHAR: begin
				req.rs = 1'b1;
				keep   = 1'b1;
			end
			clnw_pkg::FUNC_CMD: begin
				keep = 1'b1;
			end
			clnw_pkg::FUNC_POS: begin
				if (row == 2'd0) begin
					req.byte_val = clnw_pkg::CMD_ROW0 | {4'h0, column[3:0]};
					keep         = 1'b1;
				end else if (row == 2'd1) begin
					req.byte_val = clnw_pkg::CMD_ROW1 | {4'h0, column[3:0]};
					keep         = 1'b1;
				end
			end
			clnw_pkg::FUNC_NUMBER: begin
				req.kind = clnw_pkg::KIND_NUMBER;
				req.rs   = 1'b1;
				keep     = 1'b1;
			end
			clnw_pkg::FUNC_INIT: begin
				req.kind = clnw_pkg::KIND_INIT;
				keep     = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/clnw_queue.sv */
// Small request queue that decouples the front from the back sequencer.
module clnw_queue #(
	parameter int unsigned DEPTH = clnw_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  clnw_pkg::req_t  push_req,
	input  logic            pop,
	output clnw_pkg::req_t  head,
	output logic            head_valid,
	output logic            full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	clnw_pkg::req_t    entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign head       = entries_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == CNT_W'(DEPTH));

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_req;
		end
	end

endmodule

/* rtl/clnw_back.sv */
// Back end: drives one nibble per cycle from the queue head while the output is ready.
module clnw_back (
	input  logic            clk,
	input  logic            arst_n,
	input  clnw_pkg::req_t  head,
	input  logic            head_valid,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [3:0]      nibble,
	output logic            reg_select,
	output logic            last
);

	logic [clnw_pkg::STEP_W-1:0] step_q;
	logic [clnw_pkg::NUM_W-1:0]  rem_q;
	logic [clnw_pkg::NIB_W-1:0]  digit_q;

	logic                        out_valid_q;
	logic [clnw_pkg::NIB_W-1:0]  nibble_q;
	logic                        reg_select_q;
	logic                        last_q;

	logic                        adv;
	logic                        fire;
	logic                        step_last;
	logic [clnw_pkg::NUM_W-1:0]  rem_src;
	logic [clnw_pkg::NUM_W-1:0]  weight;
	logic [clnw_pkg::NUM_W-1:0]  thr;
	logic [clnw_pkg::NIB_W-1:0]  dig_nxt;
	logic [clnw_pkg::NUM_W-1:0]  rem_nxt;
	logic [clnw_pkg::NIB_W-1:0]  nib_nxt;
	logic                        rs_nxt;

	// The output register takes a new nibble whenever it is empty or being drained.
	assign adv  = !out_valid_q || out_ready;
	assign fire = adv && head_valid;
	assign pop  = fire && step_last;

	assign step_last = (head.kind == clnw_pkg::KIND_BYTE) ?
		(step_q == clnw_pkg::LAST_BYTE_STEP) : (step_q == clnw_pkg::LAST_SEQ_STEP);

	// Decimal digit extraction: compare the remainder against the nine multiples of
	// the current weight and keep the largest one that fits.
	assign rem_src = (step_q == '0) ? head.value : rem_q;
	assign weight  = clnw_pkg::digit_weight(step_q[clnw_pkg::STEP_W-1:1]);

	always_comb begin
		dig_nxt = '0;
		rem_nxt = rem_src;
		thr     = '0;
		for (int d = 1; d <= 9; d++) begin
			thr = clnw_pkg::NUM_W'(weight * clnw_pkg::NUM_W'(d));
			if (rem_src >= thr) begin
				dig_nxt = clnw_pkg::NIB_W'(d);
				rem_nxt = rem_src - thr;
			end
		end
	end

	// Select the nibble and RS level for the current step.
	always_comb begin
		case (head.kind)
			clnw_pkg::KIND_BYTE: begin
				nib_nxt = step_q[0] ? head.byte_val[3:0] : head.byte_val[7:4];
				rs_nxt  = head.rs;
			end
			clnw_pkg::KIND_INIT: begin
				nib_nxt = clnw_pkg::init_nibble(step_q);
				rs_nxt  = 1'b0;
			end
			clnw_pkg::KIND_NUMBER: begin
				nib_nxt = step_q[0] ? digit_q : clnw_pkg::ASCII_DIGIT_HI;
				rs_nxt  = 1'b1;
			end
			default: begin
				nib_nxt = '0;
				rs_nxt  = 1'b0;
			end
		endcase
	end

	// Step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				step_q <= step_last ? '0 : step_q + 1'b1;
			end
			if (adv) begin
				out_valid_q <= head_valid;
			end
		end
	end

	// Output payload and digit working registers.
	always_ff @(posedge clk) begin
		if (fire) begin
			nibble_q     <= nib_nxt;
			reg_select_q <= rs_nxt;
			last_q       <= step_last;
			if ((head.kind == clnw_pkg::KIND_NUMBER) && !step_q[0]) begin
				digit_q <= dig_nxt;
				rem_q   <= rem_nxt;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign nibble     = nibble_q;
	assign reg_select = reg_select_q;
	assign last       = last_q;

endmodule

/* rtl/char_lcd_nibble_writer_unit.sv */
// Top level of the character LCD nibble writer: front, request queue and back sequencer.
// A request is taken whenever the request queue has room; requests that cause no bus
// write (position on lines 2 and 3, unused codes) are dropped without entering it.
// The back sequencer sends one nibble transfer per cycle from the queue head while the
// output is ready, so a character, command or position request takes two transfers and
// a number or init request ten; that sequencer sets the sustained rate. The first nibble
// of a request is registered in the queue and then in the output register, and the queue
// keeps taking requests while the output waits.
module char_lcd_nibble_writer_unit #(
	parameter int unsigned QUEUE_DEPTH = clnw_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [7:0]  data_byte,
	input  logic [1:0]  row,
	input  logic [7:0]  column,
	input  logic [16:0] number_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  nibble,
	output logic        reg_select,
	output logic        last
);

	clnw_pkg::req_t front_req;
	clnw_pkg::req_t head;
	logic           keep;
	logic           push;
	logic           pop;
	logic           head_valid;
	logic           full;

	// Classify the request on the input.
	clnw_front u_front (
		.func         (func),
		.data_byte    (data_byte),
		.row          (row),
		.column       (column),
		.number_value (number_value),
		.req          (front_req),
		.keep         (keep)
	);

	// Only requests that produce bus writes enter the queue.
	assign in_ready = !full;
	assign push     = in_valid && in_ready && keep;

	clnw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_req   (front_req),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	// Sequence the nibble transfers of the queue head.
	clnw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.nibble     (nibble),
		.reg_select (reg_select),
		.last       (last)
	);

endmodule
